// File: rtl/core/csbe_pkg.sv
// package: shared types and constants of the capsule brush evaluator
`timescale 1ns / 1ps

package csbe_pkg;

  // register indexes, byte address is 8 * index
  localparam logic [2:0] REG_CENTER_X      = 3'd0;
  localparam logic [2:0] REG_CENTER_Y      = 3'd1;
  localparam logic [2:0] REG_CENTER_Z      = 3'd2;
  localparam logic [2:0] REG_ROTATION_QUAT = 3'd3;
  localparam logic [2:0] REG_HALF_LENGTH   = 3'd4;
  localparam logic [2:0] REG_RADIUS        = 3'd5;
  localparam logic [2:0] REG_FALLOFF       = 3'd6;
  localparam logic [2:0] REG_STRENGTH_MODE = 3'd7;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // reset values
  localparam logic [63:0] QUAT_RESET     = 64'h4000_0000_0000_0000;
  localparam logic [30:0] RADIUS_RESET   = 31'd256;
  localparam logic [30:0] FALLOFF_RESET  = 31'd256;
  localparam logic [16:0] STRENGTH_RESET = 17'd256;

  // rotation matrix entries, Q16
  localparam int MAT_W = 22;
  localparam logic signed [MAT_W-1:0] MAT_ONE = 22'sd65536;

  // output levels, Q16
  localparam logic signed [18:0] AIR_LEVEL   = 19'sd65536;
  localparam logic signed [18:0] SOLID_LEVEL = -19'sd65536;

  // pipeline depths of the iterative units
  localparam int SQRT_STAGES = 33;
  localparam int DIV_STAGES  = 16;

  // item flags that travel with the data
  typedef struct packed {
    logic valid;
    logic below;
    logic zero;
    logic full;
  } side_t;

endpackage

// File: rtl/core/capsule_sdf_brush_eval.sv
// top level: pipelined capsule brush signed distance evaluator
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  world_x, world_y, world_z, terrain_height
// output    out        out_valid / out_stall sdf_value
// config    in         psel/penable/pwrite  paddr, pwdata, prdata (64 bit, 8 byte stride)
//
// one item enters every cycle unless a valid output is stalled; the pipeline holds the 33 stage
// square root (one root bit per stage) and the 16 stage divider for t.
// rst is synchronous and clears all valid bits and loads register defaults.
// a stall on a valid output freezes every stage at once, nothing is lost or repeated.
// the rotation matrix is rebuilt at the edge that writes rotation_quat.

module capsule_sdf_brush_eval (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [5:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       world_x,
  input  logic signed [31:0]       world_y,
  input  logic signed [31:0]       world_z,
  input  logic signed [31:0]       terrain_height,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       sdf_value
);

  localparam int NS = csbe_pkg::SQRT_STAGES;
  localparam int ND = csbe_pkg::DIV_STAGES;
  localparam int MW = csbe_pkg::MAT_W;

  // configuration registers
  logic signed [31:0] center_x, center_y, center_z;
  logic [63:0]        rotation_quat;
  logic [30:0]        half_length, radius, falloff;
  logic [16:0]        strength_mode;
  logic signed [MW-1:0] mat [9];
  logic signed [MW-1:0] mat_next [9];
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  function automatic logic signed [MW-1:0] rnd12(input logic signed [34:0] x);
    logic signed [34:0] s;
    s = (x + 35'sd2048) >>> 12;
    return s[MW-1:0];
  endfunction

  // rotation matrix from the quaternion being written
  always_comb begin
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic signed [34:0] one;
    qw = pwdata[63:48];
    qx = pwdata[47:32];
    qy = pwdata[31:16];
    qz = pwdata[15:0];
    xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; wz = qw * qz; xz = qx * qz;
    wy = qw * qy; yz = qy * qz; wx = qw * qx;
    one = 35'sd268435456;
    mat_next[0] = rnd12(one - ((35'(yy) + 35'(zz)) <<< 1));
    mat_next[1] = rnd12((35'(xy) - 35'(wz)) <<< 1);
    mat_next[2] = rnd12((35'(xz) + 35'(wy)) <<< 1);
    mat_next[3] = rnd12((35'(xy) + 35'(wz)) <<< 1);
    mat_next[4] = rnd12(one - ((35'(xx) + 35'(zz)) <<< 1));
    mat_next[5] = rnd12((35'(yz) - 35'(wx)) <<< 1);
    mat_next[6] = rnd12((35'(xz) - 35'(wy)) <<< 1);
    mat_next[7] = rnd12((35'(yz) + 35'(wx)) <<< 1);
    mat_next[8] = rnd12(one - ((35'(xx) + 35'(yy)) <<< 1));
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      rotation_quat <= csbe_pkg::QUAT_RESET;
      half_length   <= '0;
      radius        <= csbe_pkg::RADIUS_RESET;
      falloff       <= csbe_pkg::FALLOFF_RESET;
      strength_mode <= csbe_pkg::STRENGTH_RESET;
      for (int i = 0; i < 9; i++) begin
        mat[i] <= (i % 4 == 0) ? csbe_pkg::MAT_ONE : '0;
      end
    end else if (cfg_wr) begin
      case (paddr[5:3])
        csbe_pkg::REG_CENTER_X:      center_x <= pwdata[31:0];
        csbe_pkg::REG_CENTER_Y:      center_y <= pwdata[31:0];
        csbe_pkg::REG_CENTER_Z:      center_z <= pwdata[31:0];
        csbe_pkg::REG_ROTATION_QUAT: begin
          rotation_quat <= pwdata;
          mat           <= mat_next;
        end
        csbe_pkg::REG_HALF_LENGTH:   half_length <= pwdata[30:0];
        csbe_pkg::REG_RADIUS:        radius <= pwdata[30:0];
        csbe_pkg::REG_FALLOFF:       falloff <= pwdata[30:0];
        csbe_pkg::REG_STRENGTH_MODE: strength_mode <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[5:3])
      csbe_pkg::REG_CENTER_X:      prdata = {32'b0, center_x};
      csbe_pkg::REG_CENTER_Y:      prdata = {32'b0, center_y};
      csbe_pkg::REG_CENTER_Z:      prdata = {32'b0, center_z};
      csbe_pkg::REG_ROTATION_QUAT: prdata = rotation_quat;
      csbe_pkg::REG_HALF_LENGTH:   prdata = {33'b0, half_length};
      csbe_pkg::REG_RADIUS:        prdata = {33'b0, radius};
      csbe_pkg::REG_FALLOFF:       prdata = {33'b0, falloff};
      csbe_pkg::REG_STRENGTH_MODE: prdata = {47'b0, strength_mode};
      default:                     prdata = '0;
    endcase
  end

  // global advance
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 0: offset from the centre
  logic signed [32:0] v0 [3];
  csbe_pkg::side_t s0;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (adv) begin
      s0.valid <= in_valid;
    end
    if (adv) begin
      v0[0]    <= 33'(world_x) - 33'(center_x);
      v0[1]    <= 33'(world_y) - 33'(center_y);
      v0[2]    <= 33'(world_z) - 33'(center_z);
      s0.below <= world_z < terrain_height;
      s0.zero  <= 1'b0;
      s0.full  <= 1'b0;
    end
  end

  // stage 1: nine matrix products, entry k = out * 3 + in
  logic signed [54:0] p1 [9];
  csbe_pkg::side_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= s0.valid;
    end
    if (adv) begin
      {s1.below, s1.zero, s1.full} <= {s0.below, s0.zero, s0.full};
      for (int o = 0; o < 3; o++) begin
        for (int i = 0; i < 3; i++) begin
          p1[o*3+i] <= 55'(v0[i]) * 55'(mat[i*3+o]);
        end
      end
    end
  end

  // stage 2: row sums rounded to Q33.8
  logic signed [40:0] l2 [3];
  csbe_pkg::side_t s2;
  always_ff @(posedge clk) begin
    logic signed [56:0] acc;
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2.valid <= s1.valid;
    end
    if (adv) begin
      {s2.below, s2.zero, s2.full} <= {s1.below, s1.zero, s1.full};
      for (int o = 0; o < 3; o++) begin
        acc = (57'(p1[o*3]) + 57'(p1[o*3+1]) + 57'(p1[o*3+2]) + 57'sd32768) >>> 16;
        l2[o] <= acc[40:0];
      end
    end
  end

  // stage 3: clamp to the segment and take magnitudes
  logic [31:0] a3 [3];
  csbe_pkg::side_t s3;
  always_ff @(posedge clk) begin
    logic signed [41:0] hl, lz, cz, ez, lx, ly;
    logic [41:0] mx, my, mz;
    hl = $signed({11'b0, half_length});
    lx = 42'(l2[0]);
    ly = 42'(l2[1]);
    lz = 42'(l2[2]);
    cz = (lz > hl) ? hl : ((lz < -hl) ? -hl : lz);
    ez = lz - cz;
    mx = lx[41] ? 42'(-lx) : 42'(lx);
    my = ly[41] ? 42'(-ly) : 42'(ly);
    mz = ez[41] ? 42'(-ez) : 42'(ez);
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (adv) begin
      s3.valid <= s2.valid;
    end
    if (adv) begin
      s3.below <= s2.below;
      s3.full  <= s2.full;
      s3.zero  <= (|mx[41:32]) || (|my[41:32]) || (|mz[41:32]);
      a3[0]    <= mx[31:0];
      a3[1]    <= my[31:0];
      a3[2]    <= mz[31:0];
    end
  end

  // stage 4: squares
  logic [63:0] q4 [3];
  csbe_pkg::side_t s4;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (adv) begin
      s4.valid <= s3.valid;
    end
    if (adv) begin
      {s4.below, s4.zero, s4.full} <= {s3.below, s3.zero, s3.full};
      for (int i = 0; i < 3; i++) begin
        q4[i] <= 64'(a3[i]) * 64'(a3[i]);
      end
    end
  end

  // square root pipeline, stage zero holds the sum of squares
  logic [65:0] sq_x    [NS+1];
  logic [34:0] sq_rem  [NS+1];
  logic [32:0] sq_root [NS+1];
  csbe_pkg::side_t sq_side [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].valid <= 1'b0;
    end else if (adv) begin
      sq_side[0].valid <= s4.valid;
    end
    if (adv) begin
      {sq_side[0].below, sq_side[0].zero, sq_side[0].full} <= {s4.below, s4.zero, s4.full};
      sq_x[0]    <= 66'(q4[0]) + 66'(q4[1]) + 66'(q4[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [36:0] r2;
    logic [36:0] trial;
    logic        take;
    assign r2    = {sq_rem[k], sq_x[k][65:64]};
    assign trial = {2'b0, sq_root[k], 2'b01};
    assign take  = r2 >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k+1].valid <= 1'b0;
      end else if (adv) begin
        sq_side[k+1].valid <= sq_side[k].valid;
      end
      if (adv) begin
        {sq_side[k+1].below, sq_side[k+1].zero, sq_side[k+1].full} <=
          {sq_side[k].below, sq_side[k].zero, sq_side[k].full};
        sq_x[k+1]    <= {sq_x[k][63:0], 2'b00};
        sq_rem[k+1]  <= take ? 35'(r2 - trial) : r2[34:0];
        sq_root[k+1] <= {sq_root[k][31:0], take};
      end
    end
  end

  // classify against the band and set up the divider
  logic [31:0] dv_rem [ND+1];
  logic [16:0] dv_q   [ND+1];
  csbe_pkg::side_t dv_side [ND+1];
  always_ff @(posedge clk) begin
    logic signed [34:0] band_dist, fall;
    logic [31:0] d32;
    logic        ge;
    band_dist = $signed({2'b0, sq_root[NS]}) - $signed({4'b0, radius});
    fall      = $signed({4'b0, falloff});
    d32       = band_dist[31:0];
    ge        = d32 >= {1'b0, falloff};
    if (rst) begin
      dv_side[0].valid <= 1'b0;
    end else if (adv) begin
      dv_side[0].valid <= sq_side[NS].valid;
    end
    if (adv) begin
      dv_side[0].below <= sq_side[NS].below;
      dv_side[0].zero  <= sq_side[NS].zero || (band_dist > fall);
      dv_side[0].full  <= band_dist <= 35'sd0;
      dv_rem[0]        <= ge ? (d32 - {1'b0, falloff}) : d32;
      dv_q[0]          <= {16'b0, ge};
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [31:0] r2;
    logic        take;
    assign r2   = {dv_rem[k][30:0], 1'b0};
    assign take = r2 >= {1'b0, falloff};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_side[k+1].valid <= 1'b0;
      end else if (adv) begin
        dv_side[k+1].valid <= dv_side[k].valid;
      end
      if (adv) begin
        {dv_side[k+1].below, dv_side[k+1].zero, dv_side[k+1].full} <=
          {dv_side[k].below, dv_side[k].zero, dv_side[k].full};
        dv_rem[k+1] <= take ? (r2 - {1'b0, falloff}) : r2;
        dv_q[k+1]   <= {dv_q[k][15:0], take};
      end
    end
  end

  // smoothstep, first product
  logic [33:0] tt;
  logic [17:0] poly;
  csbe_pkg::side_t sm1_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      sm1_side.valid <= 1'b0;
    end else if (adv) begin
      sm1_side.valid <= dv_side[ND].valid;
    end
    if (adv) begin
      {sm1_side.below, sm1_side.zero, sm1_side.full} <=
        {dv_side[ND].below, dv_side[ND].zero, dv_side[ND].full};
      tt   <= 34'(dv_q[ND]) * 34'(dv_q[ND]);
      poly <= 18'd196608 - {dv_q[ND], 1'b0};
    end
  end

  // smoothstep, second product and rounding
  logic [16:0] sm;
  csbe_pkg::side_t sm2_side;
  always_ff @(posedge clk) begin
    logic [51:0] p;
    p = 52'(tt) * 52'(poly) + 52'd2147483648;
    if (rst) begin
      sm2_side.valid <= 1'b0;
    end else if (adv) begin
      sm2_side.valid <= sm1_side.valid;
    end
    if (adv) begin
      {sm2_side.below, sm2_side.zero, sm2_side.full} <=
        {sm1_side.below, sm1_side.zero, sm1_side.full};
      sm <= p[48:32];
    end
  end

  // blend between the levels
  logic signed [18:0] lvl;
  csbe_pkg::side_t lp_side;
  logic dig;
  assign dig = strength_mode[16];
  always_ff @(posedge clk) begin
    logic signed [18:0] base, diff;
    logic signed [36:0] step;
    base = dig ? csbe_pkg::AIR_LEVEL : csbe_pkg::SOLID_LEVEL;
    if (!dig) begin
      diff = 19'sd65536;
    end else if (sm2_side.below) begin
      diff = -19'sd131072;
    end else begin
      diff = -19'sd65536;
    end
    step = (37'(diff) * $signed({20'b0, sm}) + 37'sd32768) >>> 16;
    if (rst) begin
      lp_side.valid <= 1'b0;
    end else if (adv) begin
      lp_side.valid <= sm2_side.valid;
    end
    if (adv) begin
      {lp_side.below, lp_side.zero, lp_side.full} <=
        {sm2_side.below, sm2_side.zero, sm2_side.full};
      if (sm2_side.zero) begin
        lvl <= '0;
      end else if (sm2_side.full) begin
        lvl <= base;
      end else begin
        lvl <= base + step[18:0];
      end
    end
  end

  // strength scaling into the output register
  always_ff @(posedge clk) begin
    logic signed [35:0] sc;
    sc = (36'(lvl) * $signed({19'b0, strength_mode[15:0]}) + 36'sd128) >>> 8;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= lp_side.valid;
    end
    if (adv) begin
      sdf_value <= sc[31:0];
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (dv_side[ND].valid && !dv_side[ND].zero && !dv_side[ND].full) |->
      (dv_q[ND] <= 17'd65536))
    else $error("blend fraction above one");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (adv && lp_side.valid && lp_side.zero) |=> (sdf_value == 32'sd0))
    else $error("item outside the band gave a non-zero beat");

endmodule
